>>> src/u2g_pkg.sv
// Shared types, constants and code page lookup functions for the UTF-8 to Greek converter.
`default_nettype none

package u2g_pkg;

    // Sequence length at which the byte counter saturates.
    localparam logic [2:0] LEN_SAT = 3'd7;

    // Result kinds as reported on the output channel.
    typedef enum logic [1:0] {
        KIND_CONV      = 2'd0,
        KIND_ASCII     = 2'd1,
        KIND_UNMAPPED  = 2'd2,
        KIND_MALFORMED = 2'd3
    } kind_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last_of_run;
    } res_t;

    // Two-byte reverse lookup; zero means there is no entry.
    function automatic logic [7:0] map_two(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] code;
        code = 8'h00;
        case (a)
            8'hC6:
            begin
                if (b == 8'h92)
                begin
                    code = 8'h83;
                end
            end
            8'hCA:
            begin
                case (b)
                    8'h81, 8'h88, 8'h8A, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90,
                    8'h98, 8'h9A, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hAA: code = b;
                    default: code = 8'h00;
                endcase
            end
            8'hCB:
            begin
                if (b == 8'h92)
                begin
                    code = 8'hD2;
                end
                else if (b == 8'hBF)
                begin
                    code = 8'hFF;
                end
            end
            8'hCE:
            begin
                case (b)
                    8'h84: code = 8'hB4;
                    8'h85: code = 8'hA1;
                    8'h86: code = 8'hA2;
                    8'h88: code = 8'hB8;
                    8'h89: code = 8'hB9;
                    8'h8A: code = 8'hBA;
                    8'h8C: code = 8'hBC;
                    8'h8E: code = 8'hBE;
                    8'h8F: code = 8'hBF;
                    default:
                    begin
                        if (b >= 8'h90 && b <= 8'hBF && b != 8'hA2)
                        begin
                            code = 8'(b + 8'h30);
                        end
                    end
                endcase
            end
            8'hCF:
            begin
                if (b >= 8'h80 && b <= 8'h8E)
                begin
                    code = 8'(b + 8'h70);
                end
            end
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Three-byte reverse lookup; zero means there is no entry.
    function automatic logic [7:0] map_three(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        logic [7:0] code;
        code = 8'h00;
        if (a == 8'hE2 && b == 8'h80)
        begin
            case (c)
                8'h93: code = 8'h96;
                8'h94: code = 8'h97;
                8'h95: code = 8'hAF;
                8'h98: code = 8'h91;
                8'h99: code = 8'h92;
                8'h9A: code = 8'h82;
                8'h9C: code = 8'h93;
                8'h9D: code = 8'h94;
                8'h9E: code = 8'h84;
                8'hA0: code = 8'h86;
                8'hA1: code = 8'h87;
                8'hA2: code = 8'h95;
                8'hA6: code = 8'h85;
                8'hB0: code = 8'h89;
                8'hB9: code = 8'h8B;
                8'hBA: code = 8'h9B;
                default: code = 8'h00;
            endcase
        end
        else if (a == 8'hE2 && b == 8'h82 && c == 8'hAC)
        begin
            code = 8'h80;
        end
        else if (a == 8'hE2 && b == 8'h84 && c == 8'hA2)
        begin
            code = 8'h99;
        end
        else if (a == 8'hEF && b == 8'hBF && c == 8'hBD)
        begin
            code = 8'hA0;
        end
        return code;
    endfunction

    // Turn a gathered sequence into one result (last_of_run left clear).
    function automatic res_t resolve(input logic [7:0] lead, input logic [7:0] second,
                                     input logic [7:0] third, input logic [2:0] len);
        res_t       r;
        logic [7:0] code;
        code = 8'h00;
        r.last_of_run = 1'b0;
        if (len < 3'd2 || len == LEN_SAT || lead[7:6] != 2'b11)
        begin
            r.out_byte = 8'h00;
            r.kind     = KIND_MALFORMED;
        end
        else
        begin
            if (len == 3'd2)
            begin
                code = map_two(lead, second);
            end
            else if (len == 3'd3)
            begin
                code = map_three(lead, second, third);
            end
            r.out_byte = code;
            r.kind     = (code != 8'h00) ? KIND_CONV : KIND_UNMAPPED;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/u2g_in_if.sv
// Input channel interface: one UTF-8 byte per transaction.
`default_nettype none

interface u2g_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

>>> src/u2g_out_if.sv
// Output channel interface: one code page result per transaction.
`default_nettype none

interface u2g_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

>>> src/u2g_conv.sv
// Sequence state and per-byte conversion logic giving up to two results per byte.
`default_nettype none

module u2g_conv (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic [7:0]    in_byte,
    input  wire logic          end_of_string,
    output logic [1:0]         res_count,
    output u2g_pkg::res_t      res0,
    output u2g_pkg::res_t      res1
);

    logic [7:0] lead_reg, lead_next;
    logic [7:0] second_reg, second_next;
    logic [7:0] third_reg, third_next;
    logic [2:0] len_reg, len_next;

    // Work out the results of the current byte and the state it leaves.
    always_comb
    begin
        u2g_pkg::res_t r_a;
        u2g_pkg::res_t r_b;
        logic          has_a;
        logic          has_b;
        logic [7:0]    sec_upd;
        logic [7:0]    thi_upd;
        logic [2:0]    len_upd;

        r_a         = '0;
        r_b         = '0;
        has_a       = 1'b0;
        has_b       = 1'b0;
        lead_next   = lead_reg;
        second_next = second_reg;
        third_next  = third_reg;
        len_next    = len_reg;
        sec_upd     = (len_reg == 3'd1) ? in_byte : second_reg;
        thi_upd     = (len_reg == 3'd2) ? in_byte : third_reg;
        len_upd     = (len_reg < u2g_pkg::LEN_SAT) ? 3'(len_reg + 3'd1) : len_reg;

        if (len_reg != 3'd0 && in_byte[7:6] == 2'b10)
        begin
            // Continuation byte joins the pending sequence.
            second_next = sec_upd;
            third_next  = thi_upd;
            len_next    = len_upd;
            if (end_of_string)
            begin
                r_a         = u2g_pkg::resolve(lead_reg, sec_upd, thi_upd, len_upd);
                has_a       = 1'b1;
                lead_next   = 8'h00;
                second_next = 8'h00;
                third_next  = 8'h00;
                len_next    = 3'd0;
            end
        end
        else
        begin
            // Any other byte first closes a pending sequence.
            if (len_reg != 3'd0)
            begin
                r_a         = u2g_pkg::resolve(lead_reg, second_reg, third_reg, len_reg);
                has_a       = 1'b1;
                lead_next   = 8'h00;
                second_next = 8'h00;
                third_next  = 8'h00;
                len_next    = 3'd0;
            end
            if (in_byte == 8'h00)
            begin
                // Terminator gives no result of its own.
            end
            else if (!in_byte[7])
            begin
                r_b.out_byte = in_byte;
                r_b.kind     = u2g_pkg::KIND_ASCII;
                has_b        = 1'b1;
            end
            else
            begin
                // A new sequence opens; on end of string it is a lone lead byte.
                lead_next   = in_byte;
                second_next = 8'h00;
                third_next  = 8'h00;
                len_next    = 3'd1;
                if (end_of_string)
                begin
                    r_b.out_byte = 8'h00;
                    r_b.kind     = u2g_pkg::KIND_MALFORMED;
                    has_b        = 1'b1;
                    lead_next    = 8'h00;
                    len_next     = 3'd0;
                end
            end
        end

        // Pack the results towards slot zero and mark the final one.
        res_count = 2'({1'b0, has_a} + {1'b0, has_b});
        if (has_a)
        begin
            res0             = r_a;
            res1             = r_b;
            res0.last_of_run = !has_b;
            res1.last_of_run = 1'b1;
        end
        else
        begin
            res0             = r_b;
            res1             = r_b;
            res0.last_of_run = 1'b1;
            res1.last_of_run = 1'b1;
        end
    end

    // Sequence state moves on only when the byte is handed on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= 8'h00;
            second_reg <= 8'h00;
            third_reg  <= 8'h00;
            len_reg    <= 3'd0;
        end
        else if (advance)
        begin
            lead_reg   <= lead_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            len_reg    <= len_next;
        end
    end

endmodule

`default_nettype wire

>>> src/utf8_to_greek_codepage_core.sv
// Top level of the UTF-8 to Greek single-byte code page converter.
//
//  channel | direction | transaction payload
//  --------+-----------+------------------------------------------
//  in_ch   | in        | in_byte[7:0], end_of_string
//  out_ch  | out       | out_byte[7:0], kind[1:0], last_of_run
//
// A byte is taken into an input register, converted combinationally against the
// sequence state, and its zero, one or two results are written to a two-entry
// result queue. One byte per cycle is sustained while the queue has room for
// its results; a byte giving two results may hold the input register while
// the queue drains.
// rst_n clears the sequence state, the input register and the queue at once.
// A stall on out_ch fills the queue and then drops in_ch.ready.
`default_nettype none

module utf8_to_greek_codepage_core (
    input  wire logic clk,
    input  wire logic rst_n,
    u2g_in_if.sink    in_ch,
    u2g_out_if.source out_ch
);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_eos_reg;

    u2g_pkg::res_t q_reg [2];
    u2g_pkg::res_t q_next [2];
    logic [1:0]    cnt_reg, cnt_next;

    logic [1:0]    res_count;
    u2g_pkg::res_t res0;
    u2g_pkg::res_t res1;
    logic          pop;
    logic [1:0]    cnt_after;
    logic          advance;
    logic [1:0]    push_count;

    // Conversion logic and sequence state.
    u2g_conv u_conv (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_byte       (s1_byte_reg),
        .end_of_string (s1_eos_reg),
        .res_count     (res_count),
        .res0          (res0),
        .res1          (res1)
    );

    // Handshake control between the input register and the result queue.
    assign pop        = (cnt_reg != 2'd0) && out_ch.ready;
    assign cnt_after  = 2'(cnt_reg - {1'b0, pop});
    assign advance    = s1_valid_reg && ((3'({1'b0, cnt_after}) + 3'({1'b0, res_count})) <= 3'd2);
    assign push_count = advance ? res_count : 2'd0;
    assign in_ch.ready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg <= in_ch.in_byte;
            s1_eos_reg  <= in_ch.end_of_string;
        end
    end

    // Result queue: shift out the head, then append new results behind the rest.
    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        if (pop)
        begin
            q_next[0] = q_reg[1];
        end
        if (cnt_after == 2'd0)
        begin
            if (push_count != 2'd0)
            begin
                q_next[0] = res0;
            end
            if (push_count == 2'd2)
            begin
                q_next[1] = res1;
            end
        end
        else if (cnt_after == 2'd1)
        begin
            if (push_count != 2'd0)
            begin
                q_next[1] = res0;
            end
        end
        cnt_next = 2'(cnt_after + push_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    // Output channel shows the head of the queue.
    assign out_ch.valid       = (cnt_reg != 2'd0);
    assign out_ch.out_byte    = q_reg[0].out_byte;
    assign out_ch.kind        = q_reg[0].kind;
    assign out_ch.last_of_run = q_reg[0].last_of_run;

endmodule

`default_nettype wire

>>> src/u2g_checker.sv
// Port-level checks on the converter's result channel, bound to the top level.
`default_nettype none

module u2g_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] out_kind
);

    // A result that is offered stays offered until its transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transaction");

    // Dropped sequences carry a zero character.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == u2g_pkg::KIND_UNMAPPED ||
                      out_kind == u2g_pkg::KIND_MALFORMED) |-> out_byte == 8'h00)
        else $error("dropped result with nonzero character");

    // Passed-through bytes are nonzero seven-bit characters.
    a_ascii_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == u2g_pkg::KIND_ASCII |-> !out_byte[7] && out_byte != 8'h00)
        else $error("passthrough result outside the ASCII range");

    // A converted sequence always yields a real character.
    a_conv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == u2g_pkg::KIND_CONV |-> out_byte != 8'h00)
        else $error("converted result with zero character");

endmodule

bind utf8_to_greek_codepage_core u2g_checker u_u2g_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_kind  (out_ch.kind)
);

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the UTF-8 to Greek code page converter core.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [7:0] PAIR_LEADS [5] = '{8'hC6, 8'hCA, 8'hCB, 8'hCE, 8'hCF};

    logic clk;
    logic rst_n;

    u2g_in_if  in_ch();
    u2g_out_if out_ch();

    utf8_to_greek_codepage_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Sequence being gathered by the predictor.
    logic [7:0] seq_lead;
    logic [7:0] seq_second;
    logic [7:0] seq_third;
    logic [2:0] seq_count;

    // Code page characters still to come out of the block, oldest first.
    u2g_pkg::res_t awaited_chars[$];

    int   fault_count;
    int   cycle_count;
    int   hold_left;
    logic src_gaps;
    logic sink_gaps;
    logic hold_req;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Two-byte sequence to code page character; zero when there is no entry.
    function automatic logic [7:0] greek_from_pair(input logic [7:0] lead,
                                                   input logic [7:0] tail);
        logic [7:0] ch;
        ch = 8'h00;
        if (lead == 8'hC6 && tail == 8'h92)
        begin
            ch = 8'h83;
        end
        else if (lead == 8'hCA)
        begin
            case (tail)
                8'h81, 8'h88, 8'h8A, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90,
                8'h98, 8'h9A, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hAA: ch = tail;
                default: ch = 8'h00;
            endcase
        end
        else if (lead == 8'hCB)
        begin
            ch = (tail == 8'h92) ? 8'hD2 : (tail == 8'hBF) ? 8'hFF : 8'h00;
        end
        else if (lead == 8'hCE)
        begin
            // Accented capitals and the tonos marks, then the plain Greek block.
            case (tail)
                8'h84: ch = 8'hB4;
                8'h85: ch = 8'hA1;
                8'h86: ch = 8'hA2;
                8'h88: ch = 8'hB8;
                8'h89: ch = 8'hB9;
                8'h8A: ch = 8'hBA;
                8'h8C: ch = 8'hBC;
                8'h8E: ch = 8'hBE;
                8'h8F: ch = 8'hBF;
                default:
                begin
                    if (tail >= 8'h90 && tail <= 8'hBF && tail != 8'hA2)
                    begin
                        ch = tail + 8'h30;
                    end
                end
            endcase
        end
        else if (lead == 8'hCF && tail >= 8'h80 && tail <= 8'h8E)
        begin
            ch = tail + 8'h70;
        end
        return ch;
    endfunction

    // Three-byte sequence to code page character; zero when there is no entry.
    function automatic logic [7:0] greek_from_triple(input logic [7:0] lead,
                                                     input logic [7:0] mid,
                                                     input logic [7:0] tail);
        logic [7:0] ch;
        ch = 8'h00;
        if (lead == 8'hE2 && mid == 8'h80)
        begin
            case (tail)
                8'h93: ch = 8'h96;
                8'h94: ch = 8'h97;
                8'h95: ch = 8'hAF;
                8'h98: ch = 8'h91;
                8'h99: ch = 8'h92;
                8'h9A: ch = 8'h82;
                8'h9C: ch = 8'h93;
                8'h9D: ch = 8'h94;
                8'h9E: ch = 8'h84;
                8'hA0: ch = 8'h86;
                8'hA1: ch = 8'h87;
                8'hA2: ch = 8'h95;
                8'hA6: ch = 8'h85;
                8'hB0: ch = 8'h89;
                8'hB9: ch = 8'h8B;
                8'hBA: ch = 8'h9B;
                default: ch = 8'h00;
            endcase
        end
        else if ({lead, mid, tail} == 24'hE282AC)
        begin
            ch = 8'h80;
        end
        else if ({lead, mid, tail} == 24'hE284A2)
        begin
            ch = 8'h99;
        end
        else if ({lead, mid, tail} == 24'hEFBFBD)
        begin
            ch = 8'hA0;
        end
        return ch;
    endfunction

    // Close the pending sequence, giving one result, and clear it.
    function automatic u2g_pkg::res_t settle_sequence();
        u2g_pkg::res_t r;
        logic [7:0]    ch;
        ch = 8'h00;
        r.last_of_run = 1'b0;
        if (seq_count < 3'd2 || seq_count == u2g_pkg::LEN_SAT || seq_lead[7:6] != 2'b11)
        begin
            r.out_byte = 8'h00;
            r.kind     = u2g_pkg::KIND_MALFORMED;
        end
        else
        begin
            if (seq_count == 3'd2)
            begin
                ch = greek_from_pair(seq_lead, seq_second);
            end
            else if (seq_count == 3'd3)
            begin
                ch = greek_from_triple(seq_lead, seq_second, seq_third);
            end
            r.out_byte = ch;
            r.kind     = (ch != 8'h00) ? u2g_pkg::KIND_CONV : u2g_pkg::KIND_UNMAPPED;
        end
        seq_lead   = 8'h00;
        seq_second = 8'h00;
        seq_third  = 8'h00;
        seq_count  = 3'd0;
        return r;
    endfunction

    // Work out the results of one accepted byte and queue them.
    function automatic void predict_byte(input logic [7:0] b, input logic eos);
        u2g_pkg::res_t fresh[$];
        u2g_pkg::res_t r;
        if (seq_count != 3'd0 && b[7:6] == 2'b10)
        begin
            // Continuation byte: only the first two after the lead are kept.
            if (seq_count == 3'd1)
            begin
                seq_second = b;
            end
            else if (seq_count == 3'd2)
            begin
                seq_third = b;
            end
            if (seq_count != u2g_pkg::LEN_SAT)
            begin
                seq_count = seq_count + 3'd1;
            end
            if (eos)
            begin
                fresh.push_back(settle_sequence());
            end
        end
        else
        begin
            if (seq_count != 3'd0)
            begin
                fresh.push_back(settle_sequence());
            end
            if (b != 8'h00 && !b[7])
            begin
                r.out_byte    = b;
                r.kind        = u2g_pkg::KIND_ASCII;
                r.last_of_run = 1'b0;
                fresh.push_back(r);
            end
            else if (b[7])
            begin
                seq_lead   = b;
                seq_second = 8'h00;
                seq_third  = 8'h00;
                seq_count  = 3'd1;
                if (eos)
                begin
                    fresh.push_back(settle_sequence());
                end
            end
        end
        if (fresh.size() != 0)
        begin
            fresh[fresh.size() - 1].last_of_run = 1'b1;
        end
        foreach (fresh[i])
        begin
            awaited_chars.push_back(fresh[i]);
        end
    endfunction

    // Predict on every input transaction and check every output transaction.
    always @(posedge clk)
    begin
        u2g_pkg::res_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_byte(in_ch.in_byte, in_ch.end_of_string);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_chars.size() == 0)
                begin
                    $error("unexpected result: out_byte %h kind %0d last_of_run %0b",
                           out_ch.out_byte, out_ch.kind, out_ch.last_of_run);
                    fault_count++;
                end
                else
                begin
                    want = awaited_chars.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, out_ch.out_byte);
                        fault_count++;
                    end
                    if (out_ch.kind !== 2'(want.kind))
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
                        fault_count++;
                    end
                    if (out_ch.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last_of_run, out_ch.last_of_run);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= !(sink_gaps && $urandom_range(99) < 35);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Offer one byte, with random idle cycles first, and wait for the transaction.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while (src_gaps && $urandom_range(99) < 35)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_string <= eos;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
    endtask

    // Send a run of bytes; end_of_string may land on the last one or, rarely, earlier.
    task automatic send_run(input logic [7:0] seq_bytes[$], input logic eos_last);
        foreach (seq_bytes[i])
        begin
            if (i == seq_bytes.size() - 1)
            begin
                send_byte(seq_bytes[i], eos_last);
            end
            else
            begin
                send_byte(seq_bytes[i], $urandom_range(99) < 4);
            end
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    task automatic test_ascii_passthrough();
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // Mapped and unmapped lookups, including a resolve by end_of_string on a tail byte.
    task automatic test_table_lookups();
        send_byte(8'hCE, 1'b0);
        send_byte(8'h91, 1'b0);
        send_byte(8'hCF, 1'b0);
        send_byte(8'h8E, 1'b1);
        send_byte(8'hCE, 1'b0);
        send_byte(8'hA2, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h94, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBD, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Lone lead, stray continuation, over-long and end_of_string on a fresh lead.
    task automatic test_malformed_and_unmapped();
        send_byte(8'hC5, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'hFF, 1'b0);
        repeat (7) send_byte(cont_byte(), 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls.
    task automatic test_output_backpressure();
        src_gaps = 1'b0;
        hold_req <= 1'b1;
        repeat (12)
        begin
            send_byte(PAIR_LEADS[$urandom_range(4)], 1'b0);
            send_byte(cont_byte(), 1'b0);
            send_byte(8'($urandom_range(8'h7F, 8'h01)), 1'b0);
        end
        src_gaps = 1'b1;
    endtask

    // Mostly well-formed sequences with random content, with some noise.
    task automatic test_random_stream();
        int         sent;
        int         pick;
        int         tmpl;
        logic [7:0] seq_bytes[$];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            src_gaps  = !(sent >= 300 && sent < 420);
            sink_gaps = src_gaps;
            seq_bytes.delete();
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                seq_bytes.push_back(8'($urandom_range(8'h7F, 8'h01)));
            end
            else if (pick < 65)
            begin
                seq_bytes.push_back(PAIR_LEADS[$urandom_range(4)]);
                seq_bytes.push_back(cont_byte());
            end
            else if (pick < 82)
            begin
                tmpl = $urandom_range(99);
                if (tmpl < 50)
                begin
                    seq_bytes = '{8'hE2, 8'h80, cont_byte()};
                end
                else if (tmpl < 65)
                begin
                    seq_bytes = '{8'hE2, 8'h82, 8'hAC};
                end
                else if (tmpl < 80)
                begin
                    seq_bytes = '{8'hE2, 8'h84, 8'hA2};
                end
                else if (tmpl < 90)
                begin
                    seq_bytes = '{8'hEF, 8'hBF, 8'hBD};
                end
                else
                begin
                    seq_bytes = '{8'($urandom_range(8'hEF, 8'hE0)), cont_byte(), cont_byte()};
                end
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(3, 1)) seq_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                // Long sequences, up to past the saturation of the length count.
                seq_bytes.push_back(8'($urandom_range(8'hFF, 8'hC0)));
                repeat ($urandom_range(9, 2)) seq_bytes.push_back(cont_byte());
            end
            send_run(seq_bytes, $urandom_range(9) == 0);
            foreach (seq_bytes[i])
            begin
                if (seq_bytes[i] != 8'h00)
                begin
                    sent++;
                end
            end
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // Reset, run the tests in turn, drain and report.
    initial
    begin
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = 8'h00;
        in_ch.end_of_string = 1'b0;
        out_ch.ready        = 1'b0;
        src_gaps            = 1'b1;
        sink_gaps           = 1'b1;
        hold_req            = 1'b0;
        hold_left           = 0;
        fault_count         = 0;
        cycle_count         = 0;
        seq_lead            = 8'h00;
        seq_second          = 8'h00;
        seq_third           = 8'h00;
        seq_count           = 3'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_passthrough();
        test_table_lookups();
        test_malformed_and_unmapped();
        test_output_backpressure();
        test_random_stream();

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && awaited_chars.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
src/u2g_pkg.sv
src/u2g_in_if.sv
src/u2g_out_if.sv
src/u2g_conv.sv
src/utf8_to_greek_codepage_core.sv
src/u2g_checker.sv
dv/tb_top.sv
